// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property while reset is released.
`define SPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property at every edge, reset included.
`define SPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/spc_pkg.sv =====
`default_nettype none

package spc_pkg;

  // Pipeline depth default and arctan table length
  localparam int unsigned CordicStagesDef = 16;
  localparam int unsigned AtanEntries     = 24;

  // Datapath widths
  localparam int unsigned PosW  = 32;  // Q15.16 position
  localparam int unsigned HdgW  = 16;  // Q2.13 heading
  localparam int unsigned NegW  = 33;  // position that may be negated
  localparam int unsigned CordW = 34;  // CORDIC x, y, z (Q.30)
  localparam int unsigned ProdW = 67;  // NegW x CordW product
  localparam int unsigned AccW  = 68;  // Q.46 sum of three terms
  localparam int unsigned RndW  = AccW - 30;

  localparam int unsigned ZShift   = 17;  // Q2.13 -> Q.30
  localparam int unsigned RndShift = 30;  // Q.46 -> Q.16

  // Angle constants in Q2.13, one guard bit
  localparam logic signed [HdgW:0] PiQ13     = 17'sd25736;
  localparam logic signed [HdgW:0] TwoPiQ13  = 17'sd51472;
  localparam logic signed [HdgW:0] HalfPiQ13 = 17'sd12868;

  // CORDIC start value 0.6072529350 in Q.30
  localparam logic signed [CordW-1:0] GainQ30 = 34'sd652032874;

  // Rounding offset and clamp bounds
  localparam logic signed [AccW-1:0] RndHalf = AccW'(64'sd536870912);
  localparam logic signed [RndW-1:0] PosMax  = RndW'(64'sd2147483647);
  localparam logic signed [RndW-1:0] PosMin  = RndW'(-64'sd2147483648);

  // atan(2^-i) in Q.30, truncated
  localparam logic [31:0] AtanQ30 [AtanEntries] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
    32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  // Operands that ride along the CORDIC chain
  typedef struct packed {
    logic signed [PosW-1:0] x1;
    logic signed [PosW-1:0] y1;
    logic signed [NegW-1:0] x2;   // negated when the heading was folded
    logic signed [NegW-1:0] y2;
    logic signed [HdgW-1:0] hdg;  // wrapped heading sum
  } pass_t;

endpackage

`default_nettype wire

// ===== rtl/spc_front.sv =====
`default_nettype none

module spc_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire logic signed [31:0]            first_x_i,
  input  wire logic signed [31:0]            first_y_i,
  input  wire logic signed [15:0]            first_heading_i,
  input  wire logic signed [31:0]            second_x_i,
  input  wire logic signed [31:0]            second_y_i,
  input  wire logic signed [15:0]            second_heading_i,
  output logic                               valid_o,
  output logic signed [spc_pkg::CordW-1:0]   z_o,
  output spc_pkg::pass_t                     pass_o
);
  import spc_pkg::*;

  logic signed [HdgW:0]   h1_ext, h2_ext, fold, hsum, hwrap;
  logic                   flip;
  logic signed [NegW-1:0] x2_ext, y2_ext;
  logic signed [CordW-1:0] z_d, z_q;
  pass_t                  pass_d, pass_q;
  logic                   valid_q;

  // Fold the first heading into [-pi/2, pi/2]
  always_comb begin
    h1_ext = {first_heading_i[HdgW-1], first_heading_i};
    priority if (h1_ext > HalfPiQ13) begin
      fold = h1_ext - PiQ13;
      flip = 1'b1;
    end else if (h1_ext < -HalfPiQ13) begin
      fold = h1_ext + PiQ13;
      flip = 1'b1;
    end else begin
      fold = h1_ext;
      flip = 1'b0;
    end
    z_d = CordW'(fold) <<< ZShift;
  end

  // Wrap the heading sum once
  always_comb begin
    h2_ext = {second_heading_i[HdgW-1], second_heading_i};
    hsum   = h1_ext + h2_ext;
    priority if (hsum > PiQ13) begin
      hwrap = hsum - TwoPiQ13;
    end else if (hsum < -PiQ13) begin
      hwrap = hsum + TwoPiQ13;
    end else begin
      hwrap = hsum;
    end
  end

  // Negate the second translation in place of negating sine and cosine
  always_comb begin
    x2_ext     = {second_x_i[PosW-1], second_x_i};
    y2_ext     = {second_y_i[PosW-1], second_y_i};
    pass_d.x1  = first_x_i;
    pass_d.y1  = first_y_i;
    pass_d.x2  = flip ? -x2_ext : x2_ext;
    pass_d.y2  = flip ? -y2_ext : y2_ext;
    pass_d.hdg = hwrap[HdgW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q    <= z_d;
      pass_q <= pass_d;
    end
  end

  assign valid_o = valid_q;
  assign z_o     = z_q;
  assign pass_o  = pass_q;

endmodule

`default_nettype wire

// ===== rtl/spc_cordic_stage.sv =====
`default_nettype none

module spc_cordic_stage #(
  parameter int unsigned Idx = 0
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire logic signed [spc_pkg::CordW-1:0] x_i,
  input  wire logic signed [spc_pkg::CordW-1:0] y_i,
  input  wire logic signed [spc_pkg::CordW-1:0] z_i,
  input  wire spc_pkg::pass_t                pass_i,
  output logic                               valid_o,
  output logic signed [spc_pkg::CordW-1:0]   x_o,
  output logic signed [spc_pkg::CordW-1:0]   y_o,
  output logic signed [spc_pkg::CordW-1:0]   z_o,
  output spc_pkg::pass_t                     pass_o
);
  import spc_pkg::*;

  localparam logic signed [CordW-1:0] Atan = CordW'({2'b00, AtanQ30[Idx]});

  logic signed [CordW-1:0] x_sh, y_sh;
  logic signed [CordW-1:0] x_d, y_d, z_d, x_q, y_q, z_q;
  pass_t                   pass_q;
  logic                    valid_q;

  // Rotate toward zero residual angle
  always_comb begin
    x_sh = x_i >>> Idx;
    y_sh = y_i >>> Idx;
    if (!z_i[CordW-1]) begin
      x_d = x_i - y_sh;
      y_d = y_i + x_sh;
      z_d = z_i - Atan;
    end else begin
      x_d = x_i + y_sh;
      y_d = y_i - x_sh;
      z_d = z_i + Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      pass_q <= pass_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign pass_o  = pass_q;

endmodule

`default_nettype wire

// ===== rtl/spc_mac.sv =====
`default_nettype none

module spc_mac (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire logic signed [spc_pkg::CordW-1:0] cos_i,
  input  wire logic signed [spc_pkg::CordW-1:0] sin_i,
  input  wire spc_pkg::pass_t                pass_i,
  output logic                               valid_o,
  output logic signed [31:0]                 out_x_o,
  output logic signed [31:0]                 out_y_o,
  output logic signed [15:0]                 out_heading_o,
  output logic                               saturated_o
);
  import spc_pkg::*;

  // Product stage
  logic                    pv_q;
  logic signed [ProdW-1:0] pxc_q, pys_q, pxs_q, pyc_q;
  logic signed [PosW-1:0]  px1_q, py1_q;
  logic signed [HdgW-1:0]  phdg_q;

  // Sum stage
  logic                    sv_q;
  logic signed [AccW-1:0]  ax_d, ay_d, ax_q, ay_q;
  logic signed [HdgW-1:0]  shdg_q;

  // Round and clamp stage
  logic                    ov_q;
  logic signed [AccW-1:0]  axr, ayr;
  logic signed [RndW-1:0]  rx, ry;
  logic signed [PosW-1:0]  ox_d, oy_d, ox_q, oy_q;
  logic                    satx, saty, sat_q;
  logic signed [HdgW-1:0]  ohdg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
      sv_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (en_i) begin
      pv_q <= valid_i;
      sv_q <= pv_q;
      ov_q <= sv_q;
    end
  end

  // Multiply the rotated translation terms
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pxc_q  <= ProdW'(pass_i.x2) * ProdW'(cos_i);
      pys_q  <= ProdW'(pass_i.y2) * ProdW'(sin_i);
      pxs_q  <= ProdW'(pass_i.x2) * ProdW'(sin_i);
      pyc_q  <= ProdW'(pass_i.y2) * ProdW'(cos_i);
      px1_q  <= pass_i.x1;
      py1_q  <= pass_i.y1;
      phdg_q <= pass_i.hdg;
    end
  end

  // Add the first translation in Q.46
  always_comb begin
    ax_d = (AccW'(px1_q) <<< RndShift) + AccW'(pxc_q) + AccW'(pys_q);
    ay_d = (AccW'(py1_q) <<< RndShift) - AccW'(pxs_q) + AccW'(pyc_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q   <= ax_d;
      ay_q   <= ay_d;
      shdg_q <= phdg_q;
    end
  end

  // Round half up to Q.16 and clamp
  always_comb begin
    axr  = ax_q + RndHalf;
    ayr  = ay_q + RndHalf;
    rx   = axr[AccW-1:RndShift];
    ry   = ayr[AccW-1:RndShift];
    satx = (rx > PosMax) || (rx < PosMin);
    saty = (ry > PosMax) || (ry < PosMin);
    priority if (rx > PosMax) begin
      ox_d = PosMax[PosW-1:0];
    end else if (rx < PosMin) begin
      ox_d = PosMin[PosW-1:0];
    end else begin
      ox_d = rx[PosW-1:0];
    end
    priority if (ry > PosMax) begin
      oy_d = PosMax[PosW-1:0];
    end else if (ry < PosMin) begin
      oy_d = PosMin[PosW-1:0];
    end else begin
      oy_d = ry[PosW-1:0];
    end
  end

  // Output register: hold while the result waits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ox_q   <= ox_d;
      oy_q   <= oy_d;
      sat_q  <= satx | saty;
      ohdg_q <= shdg_q;
    end
  end

  assign valid_o       = ov_q;
  assign out_x_o       = ox_q;
  assign out_y_o       = oy_q;
  assign out_heading_o = ohdg_q;
  assign saturated_o   = sat_q;

endmodule

`default_nettype wire

// ===== rtl/se2_pose_compose.sv =====
// Channel  | Direction | Handshake               | Payload
// -------- | --------- | ----------------------- | ---------------------------------------
// input    | in        | in_valid_i / in_ready_o | first_x/y/heading, second_x/y/heading
// output   | out       | out_valid_o/out_ready_i | out_x, out_y, out_heading, saturated
//
// A request passes one fold stage, one register per CORDIC iteration,
// then multiply, sum and round/clamp stages.
// One request is taken per cycle while the output side accepts; the CORDIC chain
// sets the depth, the 33x34 multipliers the widest stage.
// A stalled result freezes the whole pipeline; in_ready_o drops only then.
// Reset clears the valid bits only; payload registers are not reset.
`default_nettype none

module se2_pose_compose #(
  parameter int unsigned CORDIC_STAGES = spc_pkg::CordicStagesDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [31:0] first_x_i,
  input  wire logic signed [31:0] first_y_i,
  input  wire logic signed [15:0] first_heading_i,
  input  wire logic signed [31:0] second_x_i,
  input  wire logic signed [31:0] second_y_i,
  input  wire logic signed [15:0] second_heading_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      out_x_o,
  output logic signed [31:0]      out_y_o,
  output logic signed [15:0]      out_heading_o,
  output logic                    saturated_o
);
  import spc_pkg::*;

  logic                    en;
  logic                    cv [CORDIC_STAGES+1];
  logic signed [CordW-1:0] cx [CORDIC_STAGES+1];
  logic signed [CordW-1:0] cy [CORDIC_STAGES+1];
  logic signed [CordW-1:0] cz [CORDIC_STAGES+1];
  pass_t                   cp [CORDIC_STAGES+1];

  // Advance everything unless a finished result is stalled
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  assign cx[0] = GainQ30;
  assign cy[0] = '0;

  spc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (en),
    .valid_i          (in_valid_i),
    .first_x_i        (first_x_i),
    .first_y_i        (first_y_i),
    .first_heading_i  (first_heading_i),
    .second_x_i       (second_x_i),
    .second_y_i       (second_y_i),
    .second_heading_i (second_heading_i),
    .valid_o          (cv[0]),
    .z_o              (cz[0]),
    .pass_o           (cp[0])
  );

  // One register stage per CORDIC iteration
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    spc_cordic_stage #(
      .Idx (k)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cv[k]),
      .x_i     (cx[k]),
      .y_i     (cy[k]),
      .z_i     (cz[k]),
      .pass_i  (cp[k]),
      .valid_o (cv[k+1]),
      .x_o     (cx[k+1]),
      .y_o     (cy[k+1]),
      .z_o     (cz[k+1]),
      .pass_o  (cp[k+1])
    );
  end

  spc_mac u_mac (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (cv[CORDIC_STAGES]),
    .cos_i         (cx[CORDIC_STAGES]),
    .sin_i         (cy[CORDIC_STAGES]),
    .pass_i        (cp[CORDIC_STAGES]),
    .valid_o       (out_valid_o),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .out_heading_o (out_heading_o),
    .saturated_o   (saturated_o)
  );

endmodule

`default_nettype wire

// ===== rtl/spc_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module spc_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_ready_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire logic signed [31:0] out_x_i,
  input  wire logic signed [31:0] out_y_i,
  input  wire logic signed [15:0] out_heading_i,
  input  wire logic               saturated_i
);

  // A stalled result holds until taken
  `SPC_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_x_i) && $stable(out_y_i) && $stable(out_heading_i) && $stable(saturated_i), "stalled result changed")

  // Requests are taken whenever no result is waiting
  `SPC_ASSERT(a_ready_free, !out_valid_i |-> in_ready_i, "input blocked with empty output")

  // The wrapped heading stays within one turn
  `SPC_ASSERT_ALWAYS(a_hdg_range, out_valid_i |-> (out_heading_i <= 16'sd25736) && (out_heading_i >= -16'sd25736), "heading out of range")

  // A saturation flag goes with a clamped coordinate
  `SPC_ASSERT(a_sat_clamp, out_valid_i && saturated_i |-> (out_x_i == 32'sh7fffffff) || (out_x_i == 32'sh80000000) || (out_y_i == 32'sh7fffffff) || (out_y_i == 32'sh80000000), "flag without clamp")

endmodule

bind se2_pose_compose spc_checker u_spc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_ready_o),
  .out_valid_i   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .out_x_i       (out_x_o),
  .out_y_i       (out_y_o),
  .out_heading_i (out_heading_o),
  .saturated_i   (saturated_o)
);

`default_nettype wire

// ===== tb/se2_pose_compose_tb.sv =====
`default_nettype none

// One pose-pair request as driven on the input ports
typedef struct packed {
  logic signed [31:0] x1;
  logic signed [31:0] y1;
  logic signed [15:0] h1;
  logic signed [31:0] x2;
  logic signed [31:0] y2;
  logic signed [15:0] h2;
} pose_pair_t;

// One composed pose as seen on the output ports
typedef struct packed {
  logic signed [31:0] x;
  logic signed [31:0] y;
  logic signed [15:0] hdg;
  logic               sat;
} composed_pose_t;

class pose_scoreboard;
  localparam int Stages     = 16;
  localparam int HdgPi      = 25736;
  localparam int HdgTwoPi   = 51472;
  localparam int HdgHalfPi  = 12868;
  localparam longint CordicGain = 64'sd652032874;
  localparam int MaxPrinted = 20;

  // atan(2^-i) in Q.30, truncated
  localparam longint AtanTab [24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
    64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
    64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
    64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };

  composed_pose_t expected_poses[$];
  int mismatches;
  int checked;
  int saturated_seen;
  int wrapped_seen;

  function new();
    mismatches     = 0;
    checked        = 0;
    saturated_seen = 0;
    wrapped_seen   = 0;
  endfunction

  // Rotation-mode CORDIC with folding of headings beyond a quarter turn
  function void heading_sin_cos(input logic signed [15:0] hdg,
                                output longint c, output longint s);
    longint ang, x, y, z, nx;
    bit     fold;
    ang  = longint'(hdg);
    fold = 1'b0;
    if (ang > HdgHalfPi) begin
      ang  = ang - HdgPi;
      fold = 1'b1;
    end else if (ang < -HdgHalfPi) begin
      ang  = ang + HdgPi;
      fold = 1'b1;
    end
    z = ang * 131072;
    x = CordicGain;
    y = 0;
    for (int i = 0; i < Stages && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - AtanTab[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + AtanTab[i];
      end
      x = nx;
    end
    c = fold ? -x : x;
    s = fold ? -y : y;
  endfunction

  // Round a Q.46 sum to Q.16, halves up, and clamp to 32 bits
  function logic signed [31:0] round_clamp(input longint acc, inout logic sat);
    longint r;
    r = (acc + (64'sd1 <<< 29)) >>> 30;
    if (r > 64'sd2147483647) begin
      sat = 1'b1;
      r   = 64'sd2147483647;
    end else if (r < -64'sd2147483648) begin
      sat = 1'b1;
      r   = -64'sd2147483648;
    end
    return r[31:0];
  endfunction

  function composed_pose_t compose_poses(input pose_pair_t p);
    composed_pose_t res;
    longint c, s, ax, ay;
    int     psi;
    logic   sat;
    heading_sin_cos(p.h1, c, s);
    ax  = (longint'(p.x1) <<< 30) + longint'(p.x2) * c + longint'(p.y2) * s;
    ay  = (longint'(p.y1) <<< 30) - longint'(p.x2) * s + longint'(p.y2) * c;
    sat = 1'b0;
    res.x = round_clamp(ax, sat);
    res.y = round_clamp(ay, sat);
    res.sat = sat;
    // wrap the heading sum once
    psi = int'(p.h1) + int'(p.h2);
    if (psi > HdgPi) begin
      psi = psi - HdgTwoPi;
      wrapped_seen++;
    end else if (psi < -HdgPi) begin
      psi = psi + HdgTwoPi;
      wrapped_seen++;
    end
    res.hdg = psi[15:0];
    return res;
  endfunction

  function void note_request(input pose_pair_t p);
    expected_poses.push_back(compose_poses(p));
  endfunction

  function int pending();
    return expected_poses.size();
  endfunction

  task report_mismatch(input string what, input longint exp_v, input longint got_v);
    mismatches++;
    if (mismatches <= MaxPrinted)
      $display("mismatch #%0d on result %0d: %s expected %0d got %0d",
               mismatches, checked, what, exp_v, got_v);
  endtask

  task check_result(input composed_pose_t got);
    composed_pose_t exp_p;
    if (expected_poses.size() == 0) begin
      report_mismatch("unexpected result, x", 0, got.x);
      return;
    end
    exp_p = expected_poses.pop_front();
    if (got.x !== exp_p.x) report_mismatch("out_x", exp_p.x, got.x);
    if (got.y !== exp_p.y) report_mismatch("out_y", exp_p.y, got.y);
    if (got.hdg !== exp_p.hdg) report_mismatch("out_heading", exp_p.hdg, got.hdg);
    if (got.sat !== exp_p.sat) report_mismatch("saturated", exp_p.sat, got.sat);
    if (exp_p.sat) saturated_seen++;
    checked++;
  endtask
endclass

module se2_pose_compose_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Stages       = 16;
  localparam int DrainCycles  = Stages + 12;
  localparam int StallLimit   = 2000;
  localparam int PerPhase     = 667;
  localparam int HoldCycles   = 150;
  localparam int HdgPi        = 25736;
  localparam int HdgHalfPi    = 12868;
  localparam logic signed [31:0] PosMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] PosMin = 32'sh8000_0000;

  typedef enum int {PosFull, PosMid, PosSmall, PosEdge} pos_mode_e;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic signed [31:0] first_x_i;
  logic signed [31:0] first_y_i;
  logic signed [15:0] first_heading_i;
  logic signed [31:0] second_x_i;
  logic signed [31:0] second_y_i;
  logic signed [15:0] second_heading_i;
  logic out_valid_o;
  logic out_ready_i;
  logic signed [31:0] out_x_o;
  logic signed [31:0] out_y_o;
  logic signed [15:0] out_heading_o;
  logic saturated_o;

  pose_scoreboard board;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int quiet_cycles;
  int sent;

  se2_pose_compose #(.CORDIC_STAGES(Stages)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .first_x_i       (first_x_i),
    .first_y_i       (first_y_i),
    .first_heading_i (first_heading_i),
    .second_x_i      (second_x_i),
    .second_y_i      (second_y_i),
    .second_heading_i(second_heading_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_x_o         (out_x_o),
    .out_y_o         (out_y_o),
    .out_heading_o   (out_heading_o),
    .saturated_o     (saturated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic pose_pair_t make_pose(input logic signed [31:0] x1,
      input logic signed [31:0] y1, input int h1, input logic signed [31:0] x2,
      input logic signed [31:0] y2, input int h2);
    pose_pair_t p;
    p.x1 = x1;
    p.y1 = y1;
    p.h1 = h1[15:0];
    p.x2 = x2;
    p.y2 = y2;
    p.h2 = h2[15:0];
    return p;
  endfunction

  function automatic logic signed [31:0] rand_position(input pos_mode_e mode);
    case (mode)
      PosFull:  return $urandom();
      PosMid:   return int'($urandom_range(0, 33554431)) - 16777216;
      PosSmall: return int'($urandom_range(0, 8191)) - 4096;
      default:  return ($urandom_range(1, 0) == 1) ? PosMax - $urandom_range(0, 3)
                                                   : PosMin + $urandom_range(0, 3);
    endcase
  endfunction

  function automatic int rand_heading();
    case ($urandom_range(0, 15))
      0:       return HdgPi - $urandom_range(0, 1);
      1:       return -HdgPi + $urandom_range(0, 1);
      2:       return HdgHalfPi + $urandom_range(0, 1);
      3:       return -HdgHalfPi - $urandom_range(0, 1);
      default: return int'($urandom_range(0, 2 * HdgPi)) - HdgPi;
    endcase
  endfunction

  function automatic pose_pair_t random_pose();
    pos_mode_e mode;
    int        pick;
    pick = $urandom_range(0, 99);
    if (pick < 25)      mode = PosFull;
    else if (pick < 70) mode = PosMid;
    else if (pick < 92) mode = PosSmall;
    else                mode = PosEdge;
    return make_pose(rand_position(mode), rand_position(mode), rand_heading(),
                     rand_position(mode), rand_position(mode), rand_heading());
  endfunction

  // Offer one request from a falling edge and hold it until accepted
  task automatic send_pose(input pose_pair_t p);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    first_x_i        = p.x1;
    first_y_i        = p.y1;
    first_heading_i  = p.h1;
    second_x_i       = p.x2;
    second_y_i       = p.y2;
    second_heading_i = p.h2;
    in_valid_i       = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(p);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic run_directed();
    send_pose(make_pose(0, 0, 0, 0, 0, 0));
    send_pose(make_pose(0, 0, HdgHalfPi, 32'sh0001_0000, 0, 0));
    send_pose(make_pose(0, 0, HdgHalfPi + 1, 32'sh0001_0000, 32'sh0002_0000, 0));
    send_pose(make_pose(0, 0, -HdgHalfPi, 32'sh0001_0000, 32'sh0002_0000, 0));
    send_pose(make_pose(0, 0, -HdgHalfPi - 1, 32'sh0003_0000, -32'sh0001_0000, 0));
    send_pose(make_pose(5, 7, HdgPi, 11, 13, HdgPi));
    send_pose(make_pose(-5, -7, -HdgPi, -11, -13, -HdgPi));
    send_pose(make_pose(0, 0, HdgPi, 32'sh0001_0000, 0, 1));
    send_pose(make_pose(0, 0, -HdgPi, 0, 32'sh0001_0000, -1));
    send_pose(make_pose(PosMax, 0, 0, PosMax, 0, 0));
    send_pose(make_pose(PosMin, 0, 0, PosMin, 0, 0));
    send_pose(make_pose(0, PosMax, 0, 0, PosMax, 0));
    send_pose(make_pose(0, PosMin, HdgHalfPi, PosMax, 0, 0));
    send_pose(make_pose(PosMax, PosMin, 0, 0, 0, 0));
    send_pose(make_pose(0, 0, 100, 1, 1, -100));
    send_pose(make_pose(-1, -1, -1000, 3, -3, 1000));
    send_pose(make_pose(PosMax, PosMax, HdgPi, PosMax, PosMax, -HdgPi));
    send_pose(make_pose(PosMin, PosMin, -HdgPi, PosMin, PosMin, HdgPi));
    send_pose(make_pose(0, 0, HdgHalfPi, PosMin, PosMin, HdgHalfPi));
    send_pose(make_pose(32'sh0123_4567, -32'sh0076_5432, 8000,
                        -32'sh0002_8000, 32'sh0011_1111, -20000));
  endtask

  // Result side: random back-pressure, or a long hold when asked
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else begin
        out_ready_i = ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_result('{x: out_x_o, y: out_y_o, hdg: out_heading_o,
                           sat: saturated_o});
  end

  // Abort if neither channel moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("timeout: no request moved for %0d cycles", StallLimit);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    out_ready_i      = 1'b0;
    first_x_i        = '0;
    first_y_i        = '0;
    first_heading_i  = '0;
    second_x_i       = '0;
    second_y_i       = '0;
    second_heading_i = '0;
    send_idle_pct    = 18;
    recv_idle_pct    = 51;
    hold_left        = 0;
    quiet_cycles     = 0;
    sent             = 0;
    board            = new();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();

    // Three idling patterns, the last with a long result-side hold at its start
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 51;
        end
        1: begin
          send_idle_pct = 51;
          recv_idle_pct = 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_left     = HoldCycles;
        end
      endcase
      repeat (PerPhase) send_pose(random_pose());
    end
    in_valid_i = 1'b0;

    // Drain outstanding results, then watch for strays
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d pose pairs, checked %0d composed poses", sent, board.checked);
    $display("%0d results clamped, %0d heading sums wrapped, %0d mismatches",
             board.saturated_seen, board.wrapped_seen, board.mismatches);
    if (board.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/spc_pkg.sv
rtl/spc_front.sv
rtl/spc_cordic_stage.sv
rtl/spc_mac.sv
rtl/se2_pose_compose.sv
rtl/spc_checker.sv
tb/se2_pose_compose_tb.sv
